FILE: hdl/sb64_pkg.sv
// ----------------------------------------------------------------------------
// sb64_pkg
// Shared types, status codes and the symbol decode and error merge functions
// of the strict Base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sb64_pkg;

	// status codes reported with the end of a string
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_LEN   = 3'd1;
	localparam logic [2:0] ST_CHAR  = 3'd2;
	localparam logic [2:0] ST_CANON = 3'd3;
	localparam logic [2:0] ST_LONG  = 3'd4;

	// padding character
	localparam logic [7:0] CH_PAD = 8'h3D;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       last_char;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic        byte_valid;
		logic        end_of_string;
		logic [2:0]  status;
		logic [15:0] out_count;
	} out_word_t;

	// one decoded group plus the end report, as queued for the back end
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  nbytes;
		logic        eos;
		logic [2:0]  status;
		logic [15:0] count;
	} entry_t;

	// symbol value of a character: {valid, value}
	function automatic logic [6:0] sym_decode(input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		if (c inside {[8'h41:8'h5A]}) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

	// keep the first error, but too long wins and bad char replaces canonical
	function automatic logic [2:0] note_err(input logic [2:0] cur, input logic [2:0] e);
		logic [2:0] r;
		r = cur;
		if (cur == ST_OK || e == ST_LONG || (e == ST_CHAR && cur == ST_CANON)) begin
			r = e;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/sb64_front.sv
// ----------------------------------------------------------------------------
// sb64_front
// Takes one character a cycle while the queue is not full, tracks group position,
// accumulator, padding, error and counts, and pushes a group entry when bytes or an end result.
// ----------------------------------------------------------------------------
`default_nettype none

module sb64_front #(
	parameter int MAX_TEXT_CHARS = 65536
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  sb64_pkg::in_word_t  in_word,
	input  wire                 q_full,
	output logic                q_push,
	output sb64_pkg::entry_t    q_data
);
	import sb64_pkg::*;

	localparam int CW = $clog2(MAX_TEXT_CHARS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_TEXT_CHARS);

	logic [1:0]    gp_q, gp_d;
	logic [17:0]   acc_q, acc_d;
	logic [1:0]    pad_q, pad_d;
	logic [2:0]    err_q, err_d;
	logic [15:0]   bc_q, bc_d;
	logic [CW-1:0] cc_q, cc_d;

	logic [6:0]    sym_r;
	logic [5:0]    sym;
	logic [1:0]    nb;
	logic [23:0]   word;
	logic [16:0]   bc_sum;
	logic [2:0]    st;
	logic          take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	// next state and group entry for the word at the input
	always_comb begin
		gp_d   = gp_q;
		acc_d  = acc_q;
		pad_d  = pad_q;
		err_d  = err_q;
		bc_d   = bc_q;
		cc_d   = cc_q;
		nb     = 2'd0;
		word   = '0;
		sym    = '0;
		st     = ST_OK;
		bc_sum = '0;
		sym_r  = sym_decode(in_word.char_code);
		q_data = '0;
		if (in_word.has_char) begin
			if (cc_q >= CMAX) begin
				err_d = note_err(err_d, ST_LONG);
			end else begin
				cc_d = cc_q + CW'(1);
				// padding placement and symbol check
				if (in_word.char_code == CH_PAD) begin
					if (gp_q == 2'd2 && pad_q == 2'd0) begin
						pad_d = 2'd1;
					end else if (gp_q == 2'd3 && pad_q < 2'd2) begin
						pad_d = pad_q + 2'd1;
					end else begin
						err_d = note_err(err_d, ST_CHAR);
					end
				end else if (!sym_r[6] || pad_q != 2'd0) begin
					err_d = note_err(err_d, ST_CHAR);
				end else begin
					sym = sym_r[5:0];
				end
				// group completion
				if (gp_q == 2'd3) begin
					word = {acc_q, sym};
					nb   = 2'd3;
					if (pad_d == 2'd1) begin
						if (acc_q[1:0] != 2'd0) begin
							err_d = note_err(err_d, ST_CANON);
						end
						nb = 2'd2;
					end else if (pad_d == 2'd2) begin
						if (acc_q[9:6] != 4'd0) begin
							err_d = note_err(err_d, ST_CANON);
						end
						nb = 2'd1;
					end
					if (err_d == ST_OK) begin
						bc_sum = {1'b0, bc_q} + 17'(nb);
						bc_d   = bc_sum[16] ? COUNT_MAX : bc_sum[15:0];
					end else begin
						nb = 2'd0;
					end
					acc_d = '0;
					gp_d  = 2'd0;
				end else begin
					acc_d = {acc_q[11:0], sym};
					gp_d  = gp_q + 2'd1;
				end
			end
		end
		q_data.bytes  = word;
		q_data.nbytes = nb;
		// end of string report and clear
		if (in_word.last_char) begin
			if (err_d == ST_LONG) begin
				st = ST_LONG;
			end else if (gp_d != 2'd0) begin
				st = ST_LEN;
			end else begin
				st = err_d;
			end
			q_data.eos    = 1'b1;
			q_data.status = st;
			q_data.count  = (st == ST_OK) ? bc_d : 16'd0;
			gp_d  = '0;
			acc_d = '0;
			pad_d = '0;
			err_d = ST_OK;
			bc_d  = '0;
			cc_d  = '0;
		end
		q_push = take && (nb != 2'd0 || in_word.last_char);
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q  <= '0;
			acc_q <= '0;
			pad_q <= '0;
			err_q <= ST_OK;
			bc_q  <= '0;
			cc_q  <= '0;
		end else if (take) begin
			gp_q  <= gp_d;
			acc_q <= acc_d;
			pad_q <= pad_d;
			err_q <= err_d;
			bc_q  <= bc_d;
			cc_q  <= cc_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sb64_queue.sv
// ----------------------------------------------------------------------------
// sb64_queue
// Short first-in first-out store of group entries between the front and
// the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sb64_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  sb64_pkg::entry_t    push_data,
	output logic                full,
	input  wire                 pop,
	output sb64_pkg::entry_t    head,
	output logic                empty
);
	import sb64_pkg::*;

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sb64_back.sv
// ----------------------------------------------------------------------------
// sb64_back
// Splits each queued group entry into result words, one a cycle while the
// receiver is ready, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sb64_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sb64_pkg::entry_t    head,
	input  wire                 empty,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output sb64_pkg::out_word_t out_word
);
	import sb64_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] fin;
	logic       load;
	logic       at_end;
	out_word_t  nxt;
	logic       out_valid_q;
	out_word_t  out_word_q;

	assign fin    = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
	assign at_end = (idx_q == fin);
	assign load   = !empty && (!out_valid_q || out_ready);
	assign pop    = load && at_end;

	// result word for the current position in the head entry
	always_comb begin
		nxt            = '0;
		nxt.byte_valid = (head.nbytes != 2'd0);
		if (nxt.byte_valid) begin
			case (idx_q)
				2'd0:    nxt.byte_value = head.bytes[23:16];
				2'd1:    nxt.byte_value = head.bytes[15:8];
				default: nxt.byte_value = head.bytes[7:0];
			endcase
		end
		if (at_end && head.eos) begin
			nxt.end_of_string = 1'b1;
			nxt.status        = head.status;
			nxt.out_count     = head.count;
		end
	end

	// position within the entry and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

FILE: hdl/strict_base64_decoder.sv
// ----------------------------------------------------------------------------
// strict_base64_decoder
// Strict Base64 decoder: characters in, decoded bytes and an end report out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_word carries one character a word, with
// has_char and last_char marks; an end with no character is a word with
// has_char low. Output channel out_valid/out_ready/out_word carries one
// decoded byte a word; the last word of a string has end_of_string set with
// status and byte count, or is a word with no byte if the final character
// gave none. A string with a non-zero status is to be discarded.
// Throughput: one character a cycle and one result word a cycle while the
// receiver is ready. A full group gives three words for four characters, so
// the back end keeps up. The front writes the entry of an accepted character
// into a four-entry queue, and the back end registers the result word from
// the queue head in the output register. When the receiver stalls, the queue
// fills and in_ready stays low while it holds four entries, whatever the
// character at the input.
// Reset clears the string state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_base64_decoder #(
	parameter int MAX_TEXT_CHARS = 65536
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  sb64_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  wire                 out_ready,
	output sb64_pkg::out_word_t out_word
);
	import sb64_pkg::*;

	logic   q_full, q_empty, q_push, q_pop;
	entry_t q_data, q_head;

	// character classification and group assembly
	sb64_front #(
		.MAX_TEXT_CHARS(MAX_TEXT_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_data)
	);

	// group entry queue
	sb64_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// byte serialiser
	sb64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

`ifndef NO_ASSERTIONS
	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overflow");

	// a word without a byte only ever carries the end of a string
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.byte_valid) |-> out_word.end_of_string)
		else $error("byteless word without end mark");

	// status and count are zero away from the end
	a_mid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.end_of_string) |->
		(out_word.status == ST_OK && out_word.out_count == 16'd0))
		else $error("status or count set mid-string");

	// a non-zero count only comes with an ok status
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.status != ST_OK) |-> out_word.out_count == 16'd0)
		else $error("count reported with error status");
`endif

endmodule

`default_nettype wire

FILE: dv/strict_base64_decoder_chk.sv
// ----------------------------------------------------------------------------
// strict_base64_decoder_chk
// Watches both channels of the strict Base64 decoder. Every accepted
// character word goes through a local decode of the string state, and the
// byte words it should produce are queued. Every accepted output word is
// compared field by field with the oldest queued word. Failures are counted
// and handed back to the testbench top, together with the number of words
// still outstanding.
// ----------------------------------------------------------------------------
module strict_base64_decoder_chk #(
	parameter int MAX_TEXT_CHARS = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  sb64_pkg::in_word_t  in_word,
	input  logic                out_valid,
	input  logic                out_ready,
	input  sb64_pkg::out_word_t out_word,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import sb64_pkg::*;

	// string state of the decode
	logic [1:0]  grp_pos;
	logic [17:0] grp_bits;
	logic [1:0]  pad_cnt;
	logic [2:0]  str_err;
	logic [15:0] str_bytes;
	int          str_chars;

	out_word_t   byte_words_q [$];
	out_word_t   oldest;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// value of a Base64 symbol, bit 6 set when the character is in the alphabet
	function automatic logic [6:0] symbol_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return {1'b1, 6'(c - 8'd65)};
		if (c >= "a" && c <= "z") return {1'b1, 6'(c - 8'd71)};
		if (c >= "0" && c <= "9") return {1'b1, 6'(c + 8'd4)};
		if (c == "+") return 7'h7E;
		if (c == "/") return 7'h7F;
		return 7'h00;
	endfunction

	// too long overrides anything, bad char overrides non-canonical, else first wins
	function automatic logic [2:0] merged_err(input logic [2:0] now, input logic [2:0] e);
		if (now == ST_OK || e == ST_LONG) return e;
		if (e == ST_CHAR && now == ST_CANON) return e;
		return now;
	endfunction

	task automatic clear_string();
		grp_pos   = '0;
		grp_bits  = '0;
		pad_cnt   = '0;
		str_err   = ST_OK;
		str_bytes = '0;
		str_chars = 0;
	endtask

	// work out the byte words of one character word and queue them
	task automatic decode_word(input in_word_t w);
		out_word_t   res [3];
		int          nres;
		int          nb;
		logic [6:0]  sv;
		logic [5:0]  sym;
		logic [23:0] grp;
		logic [2:0]  st;
		nres = 0;
		for (int i = 0; i < 3; i++) res[i] = '0;
		if (w.has_char) begin
			if (str_chars >= MAX_TEXT_CHARS) begin
				str_err = merged_err(str_err, ST_LONG);
			end else begin
				str_chars++;
				sym = '0;
				sv  = symbol_value(w.char_code);
				// padding only in the last two places of a group
				if (w.char_code == CH_PAD) begin
					if (grp_pos == 2'd2 && pad_cnt == 2'd0) pad_cnt = 2'd1;
					else if (grp_pos == 2'd3 && pad_cnt < 2'd2) pad_cnt++;
					else str_err = merged_err(str_err, ST_CHAR);
				end else if (!sv[6] || pad_cnt != 2'd0) begin
					str_err = merged_err(str_err, ST_CHAR);
				end else begin
					sym = sv[5:0];
				end
				// group complete: check trailing bits, then emit the bytes
				if (grp_pos == 2'd3) begin
					grp = {grp_bits, sym};
					nb  = 3;
					if (pad_cnt == 2'd1) begin
						if (grp_bits[1:0] != 2'd0) str_err = merged_err(str_err, ST_CANON);
						nb = 2;
					end else if (pad_cnt == 2'd2) begin
						if (grp_bits[9:6] != 4'd0) str_err = merged_err(str_err, ST_CANON);
						nb = 1;
					end
					if (str_err == ST_OK) begin
						for (int k = 0; k < nb; k++) begin
							res[nres].byte_value = 8'(grp >> (16 - 8 * k));
							res[nres].byte_valid = 1'b1;
							nres++;
							if (str_bytes != COUNT_MAX) str_bytes++;
						end
					end
					grp_bits = '0;
					grp_pos  = '0;
				end else begin
					grp_bits = {grp_bits[11:0], sym};
					grp_pos++;
				end
			end
		end
		// end of string report rides on the last word of this step
		if (w.last_char) begin
			if (str_err == ST_LONG) st = ST_LONG;
			else if (grp_pos != 2'd0) st = ST_LEN;
			else st = str_err;
			if (nres == 0) nres = 1;
			res[nres - 1].end_of_string = 1'b1;
			res[nres - 1].status        = st;
			res[nres - 1].out_count     = (st == ST_OK) ? str_bytes : 16'd0;
			clear_string();
		end
		for (int k = 0; k < nres; k++) byte_words_q.push_back(res[k]);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		fail_count++;
		$display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// predict on accepted characters, compare accepted byte words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_string();
			byte_words_q.delete();
		end else begin
			if (in_valid && in_ready) decode_word(in_word);
			if (out_valid && out_ready) begin
				if (byte_words_q.size() == 0) begin
					report("word with nothing expected", out_word, 0);
				end else begin
					oldest = byte_words_q.pop_front();
					if (out_word.byte_value != oldest.byte_value)
						report("byte_value", out_word.byte_value, oldest.byte_value);
					if (out_word.byte_valid != oldest.byte_valid)
						report("byte_valid", out_word.byte_valid, oldest.byte_valid);
					if (out_word.end_of_string != oldest.end_of_string)
						report("end_of_string", out_word.end_of_string, oldest.end_of_string);
					if (out_word.status != oldest.status)
						report("status", out_word.status, oldest.status);
					if (out_word.out_count != oldest.out_count)
						report("out_count", out_word.out_count, oldest.out_count);
				end
			end
		end
		pending = byte_words_q.size();
	end

endmodule

FILE: dv/strict_base64_decoder_tb.sv
// ----------------------------------------------------------------------------
// strict_base64_decoder_tb
// Drives the strict Base64 decoder with directed strings (alphabet edges,
// padding, non-canonical groups, bad and misplaced characters, length
// errors and empty strings) and then random strings, mostly well formed
// with some damaged. Both channels idle at random.
// Checking is done in strict_base64_decoder_chk; this top gives the verdict.
// ----------------------------------------------------------------------------
module strict_base64_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sb64_pkg::*;

	localparam int MAX_CHARS   = 65536;
	localparam int RAND_ITEMS  = 180;
	localparam int STALL_LIMIT = 1000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	int        fail_count;
	int        pending;
	int        n_items;
	bit        steady;
	logic [7:0] text_q [$];

	strict_base64_decoder #(
		.MAX_TEXT_CHARS(MAX_CHARS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	strict_base64_decoder_chk #(
		.MAX_TEXT_CHARS(MAX_CHARS)
	) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: stalls about 8 percent of the time unless steady
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= steady || ($urandom_range(0, 99) >= 8);
		end
	end

	// end the run if nothing moves on either channel for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		if (v < 6'd26) return 8'h41 + 8'(v);
		if (v < 6'd52) return 8'h47 + 8'(v);
		if (v < 6'd62) return 8'(v) - 8'd4;
		if (v == 6'd62) return "+";
		return "/";
	endfunction

	// one word on the input channel, at times with a random gap before it
	task automatic send_word(input logic [7:0] c, input logic has, input logic last);
		in_word_t w;
		int       gap;
		w.char_code = c;
		w.has_char  = has;
		w.last_char = last;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 4) gap = $urandom_range(1, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (has || last) n_items++;
	endtask

	// send text_q as one string, end mark on the last character or apart
	task automatic send_queue(input bit end_apart);
		for (int i = 0; i < text_q.size(); i++) begin
			// words with neither character nor end are ignored by the block
			if ($urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
			send_word(text_q[i], 1'b1, !end_apart && (i == text_q.size() - 1));
		end
		if (end_apart || text_q.size() == 0) send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic send_text(input string s, input bit end_apart);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
		send_queue(end_apart);
	endtask

	initial begin : stimulus
		int         ngroups;
		int         tail;
		int         damage;
		logic [5:0] s0, s1, s2;
		in_valid = 1'b0;
		in_word  = '0;
		steady   = 1'b0;
		n_items  = 0;
		arst_n   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed strings
		send_text("", 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_text("TWFu", 1'b1);
		send_text("AAAA////++++09az", 1'b0);
		send_text("TQ==", 1'b0);
		send_text("TWE=", 1'b0);
		send_text("TR==", 1'b0);
		send_text("TWF=", 1'b0);
		send_text("TWE", 1'b0);
		send_text("TW!u", 1'b0);
		send_text("=AAA", 1'b0);
		send_text("TWE==", 1'b0);
		send_text("TR==AAAA", 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word("A", 1'b1, 1'b0);
		send_word("A", 1'b1, 1'b1);
		send_text("QUJD", 1'b0);

		// random strings
		n_items = 0;
		while (n_items < RAND_ITEMS) begin
			steady = (n_items >= 100 && n_items < 170);
			text_q.delete();
			ngroups = $urandom_range(0, 3);
			for (int g = 0; g < 4 * ngroups; g++) text_q.push_back(b64_char(6'($urandom)));
			tail = $urandom_range(0, 2);
			s0 = 6'($urandom);
			s1 = 6'($urandom);
			s2 = 6'($urandom);
			// padded tails, mostly with clean trailing bits
			if (tail == 1) begin
				if ($urandom_range(0, 3) != 0) s1[3:0] = 4'd0;
				text_q.push_back(b64_char(s0));
				text_q.push_back(b64_char(s1));
				text_q.push_back(CH_PAD);
				text_q.push_back(CH_PAD);
			end else if (tail == 2) begin
				if ($urandom_range(0, 3) != 0) s2[1:0] = 2'd0;
				text_q.push_back(b64_char(s0));
				text_q.push_back(b64_char(s1));
				text_q.push_back(b64_char(s2));
				text_q.push_back(CH_PAD);
			end
			// damage a share of the strings
			damage = $urandom_range(0, 10);
			if (damage == 7 && text_q.size() != 0) begin
				text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
			end else if (damage == 8 && text_q.size() != 0) begin
				void'(text_q.pop_back());
			end else if (damage == 9) begin
				text_q.delete();
				repeat ($urandom_range(1, 9)) text_q.push_back(8'($urandom));
			end else if (damage == 10) begin
				text_q.insert($urandom_range(0, text_q.size()), CH_PAD);
			end
			send_queue($urandom_range(0, 4) == 0);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// drain, then watch for anything unexpected
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: strict_base64_decoder.f
hdl/sb64_pkg.sv
hdl/sb64_front.sv
hdl/sb64_queue.sv
hdl/sb64_back.sv
hdl/strict_base64_decoder.sv
dv/strict_base64_decoder_chk.sv
dv/strict_base64_decoder_tb.sv
